>>> design/keyed_rotate_xor_unpacker_unit_assert.svh
// ----------------------------------------------------------------------------
// keyed rotate-xor unpacker: assertion macros
// Concurrent checks that are left out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef KEYED_ROTATE_XOR_UNPACKER_UNIT_ASSERT_SVH
`define KEYED_ROTATE_XOR_UNPACKER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define KRXU_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("krxu check failed");
`define KRXU_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("krxu check failed");
`else
`define KRXU_ASSERT(lbl, ck, rst_n, prop)
`define KRXU_ASSERT_NEXT(lbl, ck, rst_n, ante, cons)
`endif

`endif

>>> design/krxu_pkg.sv
// ----------------------------------------------------------------------------
// krxu_pkg
// Types, constants and helper functions of the keyed rotate-xor unpacker.
// ----------------------------------------------------------------------------
package krxu_pkg;

	localparam int FUNC_W      = 2;
	localparam int BYTE_W      = 8;
	localparam int STATUS_W    = 3;
	localparam int LEN_W       = 24;
	localparam int ROT_W       = 8;
	localparam int SUM_W       = 32;
	localparam int HASH_W      = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	localparam int MAX_KEY     = 127;
	localparam int KEY_CNT_W   = $clog2(MAX_KEY + 1);
	localparam logic [KEY_CNT_W-1:0] MAX_KEY_BYTES = KEY_CNT_W'(MAX_KEY);

	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
	localparam logic [SUM_W-1:0]  KEY_MIX   = 32'hA5A5_A5A5;
	localparam int                KEY_ROTL  = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_KEY     = 2'd0,
		FN_END     = 2'd1,
		FN_PAYLOAD = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_KEY_TAKEN = 3'd0,
		ST_KEY_GOOD  = 3'd1,
		ST_KEY_WRONG = 3'd2,
		ST_DECODED   = 3'd3,
		ST_SUM_OK    = 3'd4,
		ST_SUM_BAD   = 3'd5,
		ST_REJECT    = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAYLOAD_LENGTH = 2'd0,
		REG_ROTATE_AMOUNT  = 2'd1,
		REG_EXPECTED_TOTAL = 2'd2,
		REG_KEY_DIGEST     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0]  payload_length;
		logic [ROT_W-1:0]  rotate_amount;
		logic [SUM_W-1:0]  expected_total;
		logic [HASH_W-1:0] key_digest;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [FUNC_W-1:0] func;
		logic [BYTE_W-1:0] data;
	} stage_t;

	// multiply by the fnv prime 2^40 + 0x1b3 as a shift-add
	function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
		input logic [BYTE_W-1:0] b);
		logic [HASH_W-1:0] x;
		x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	function automatic logic [BYTE_W-1:0] rotr8(input logic [BYTE_W-1:0] v,
		input logic [2:0] r);
		logic [2*BYTE_W-1:0] w;
		w = {v, v} >> r;
		return w[BYTE_W-1:0];
	endfunction

	function automatic logic [BYTE_W-1:0] key_byte(input logic [LEN_W-1:0] len,
		input logic [SUM_W-1:0] total);
		logic [BYTE_W-1:0] x;
		x = len[BYTE_W-1:0] ^ total[BYTE_W-1:0] ^ KEY_MIX[BYTE_W-1:0];
		return {x[BYTE_W-1-KEY_ROTL:0], x[BYTE_W-1:BYTE_W-KEY_ROTL]};
	endfunction

endpackage

>>> design/krxu_in_if.sv
// ----------------------------------------------------------------------------
// krxu_in_if
// Input word channel: function code and data byte.
// ----------------------------------------------------------------------------
interface krxu_in_if;
	logic                          valid;
	logic                          ready;
	logic [krxu_pkg::FUNC_W-1:0]   func;
	logic [krxu_pkg::BYTE_W-1:0]   data_in;

	modport source (output valid, output func, output data_in, input ready);
	modport sink   (input valid, input func, input data_in, output ready);
endinterface

>>> design/krxu_out_if.sv
// ----------------------------------------------------------------------------
// krxu_out_if
// Result word channel: decoded byte, status code and last flag.
// ----------------------------------------------------------------------------
interface krxu_out_if;
	logic                          valid;
	logic                          ready;
	logic [krxu_pkg::BYTE_W-1:0]   data_out;
	logic [krxu_pkg::STATUS_W-1:0] status;
	logic                          last;

	modport source (output valid, output data_out, output status, output last, input ready);
	modport sink   (input valid, input data_out, input status, input last, output ready);
endinterface

>>> design/keyed_rotate_xor_unpacker_unit.sv
// ----------------------------------------------------------------------------
// keyed_rotate_xor_unpacker_unit
// Key check by 64-bit FNV-1a and rotate-xor payload decode with a byte sum.
// ----------------------------------------------------------------------------
// One word in per cycle while no result waits unread, one result out per
// word. An accepted word lands in the input register; its result goes into
// the result register when the core takes it, which waits while a result is
// unread. The cycle is set by the key hash loop: xor and constant multiply
// by the FNV prime feeding hash state. The next word is taken while a result
// waits to be read. No clearing pass after reset; configuration is to be
// written only while the unit is idle, which the unit does not enforce.
module keyed_rotate_xor_unpacker_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [krxu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [krxu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	krxu_in_if.sink                          req,
	krxu_out_if.source                       rsp
);
	import krxu_pkg::*;

	cfg_t   cfg;
	stage_t stage_s1;
	logic   take;

	krxu_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	krxu_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.stage_s1 (stage_s1),
		.req      (req)
	);

	krxu_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.stage_s1 (stage_s1),
		.take     (take),
		.rsp      (rsp)
	);
endmodule

>>> design/krxu_cfg_regs.sv
// ----------------------------------------------------------------------------
// krxu_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module krxu_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [krxu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [krxu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output krxu_pkg::cfg_t                      cfg
);
	import krxu_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PAYLOAD_LENGTH: cfg_q.payload_length <= cfg_wdata[LEN_W-1:0];
				REG_ROTATE_AMOUNT:  cfg_q.rotate_amount  <= cfg_wdata[ROT_W-1:0];
				REG_EXPECTED_TOTAL: cfg_q.expected_total <= cfg_wdata[SUM_W-1:0];
				REG_KEY_DIGEST:     cfg_q.key_digest     <= cfg_wdata[HASH_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> design/krxu_in_stage.sv
// ----------------------------------------------------------------------------
// krxu_in_stage
// Input register; takes a new word when empty or when the core drains the current one.
// ----------------------------------------------------------------------------
module krxu_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	output krxu_pkg::stage_t  stage_s1,
	krxu_in_if.sink           req
);
	import krxu_pkg::*;

	logic              valid_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              load;

	assign req.ready = !valid_s1 || take;
	assign load      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			func_s1 <= req.func;
			data_s1 <= req.data_in;
		end
	end

	assign stage_s1 = '{valid: valid_s1, func: func_s1, data: data_s1};
endmodule

>>> design/krxu_core.sv
// ----------------------------------------------------------------------------
// krxu_core
// Key hash, verification, payload decode and running sum, with result register.
// ----------------------------------------------------------------------------
`include "keyed_rotate_xor_unpacker_unit_assert.svh"

module krxu_core (
	input  logic              clk,
	input  logic              arst_n,
	input  krxu_pkg::cfg_t    cfg,
	input  krxu_pkg::stage_t  stage_s1,
	output logic              take,
	krxu_out_if.source        rsp
);
	import krxu_pkg::*;

	logic [HASH_W-1:0]    hash_q, hash_d;
	logic [KEY_CNT_W-1:0] kseen_q, kseen_d;
	logic                 verified_q, verified_d;
	logic [LEN_W-1:0]     decoded_q, decoded_d;
	logic [SUM_W-1:0]     total_q, total_d;

	logic                 out_valid_q;
	logic [BYTE_W-1:0]    data_out_q, res_data;
	status_t              status_q, res_status;
	logic                 last_q, res_last;

	logic                 is_key, is_end, is_pay;
	logic                 reject;
	logic [BYTE_W-1:0]    plain;

	assign take   = stage_s1.valid && (!out_valid_q || rsp.ready);
	assign is_key = stage_s1.func == FN_KEY;
	assign is_end = stage_s1.func == FN_END;
	assign is_pay = stage_s1.func == FN_PAYLOAD;

	assign reject = !verified_q || (cfg.payload_length == '0) ||
		(decoded_q >= cfg.payload_length);
	assign plain  = rotr8(stage_s1.data, cfg.rotate_amount[2:0]) ^
		key_byte(cfg.payload_length, cfg.expected_total);

	always_comb begin
		hash_d     = hash_q;
		kseen_d    = kseen_q;
		verified_d = verified_q;
		decoded_d  = decoded_q;
		total_d    = total_q;
		res_data   = '0;
		res_status = ST_REJECT;
		res_last   = 1'b0;
		unique case (func_t'(stage_s1.func))
			FN_KEY: begin
				if (kseen_q < MAX_KEY_BYTES) begin
					hash_d  = fnv_step(hash_q, stage_s1.data);
					kseen_d = kseen_q + 1'b1;
				end
				res_status = ST_KEY_TAKEN;
			end
			FN_END: begin
				verified_d = hash_q == cfg.key_digest;
				hash_d     = FNV_BASIS;
				kseen_d    = '0;
				decoded_d  = '0;
				total_d    = '0;
				res_status = verified_d ? ST_KEY_GOOD : ST_KEY_WRONG;
			end
			FN_PAYLOAD: begin
				if (!reject) begin
					decoded_d = decoded_q + 1'b1;
					total_d   = total_q + {{(SUM_W-BYTE_W){1'b0}}, plain};
					res_data  = plain;
					res_last  = decoded_d == cfg.payload_length;
					if (res_last) begin
						res_status = (total_d == cfg.expected_total) ? ST_SUM_OK : ST_SUM_BAD;
					end else begin
						res_status = ST_DECODED;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= FNV_BASIS;
			kseen_q     <= '0;
			verified_q  <= 1'b0;
			decoded_q   <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				hash_q     <= hash_d;
				kseen_q    <= kseen_d;
				verified_q <= verified_d;
				decoded_q  <= decoded_d;
				total_q    <= total_d;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_out_q <= res_data;
			status_q   <= res_status;
			last_q     <= res_last;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.data_out = data_out_q;
	assign rsp.status   = status_q;
	assign rsp.last     = last_q;

	`KRXU_ASSERT_NEXT(a_end_clears, clk, arst_n, take && is_end,
		decoded_q == '0 && total_q == '0 && kseen_q == '0 && hash_q == FNV_BASIS)
	`KRXU_ASSERT_NEXT(a_key_cap_holds, clk, arst_n, take && is_key && kseen_q == MAX_KEY_BYTES,
		$stable(hash_q) && $stable(kseen_q))
	`KRXU_ASSERT_NEXT(a_unverified_reject, clk, arst_n, take && is_pay && !verified_q,
		out_valid_q && status_q == ST_REJECT && data_out_q == '0 && !last_q)
endmodule
